@@ hdl/m2e_pkg.sv @@
// Shared width offsets for the 2x2 real eigenvalue block.
package m2e_pkg;

    // root of the discriminant is this many bits wider than a matrix entry
    localparam int ROOT_EXTRA   = 2;
    // eigenvalue fields are this many bits wider than a matrix entry
    localparam int LAMBDA_EXTRA = 3;
    // eigenvector y fields are this many bits wider than a matrix entry
    localparam int VEC_EXTRA    = 4;

endpackage

@@ hdl/m2e_if.sv @@
// Stream interfaces for matrix transactions and eigen result transactions.
interface m2e_in_if #(
    parameter int DW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;

    modport source (output valid, m00, m01, m10, m11, input ready);
    modport sink   (input valid, m00, m01, m10, m11, output ready);
endinterface

interface m2e_out_if #(
    parameter int DW = 16
);
    logic                                        valid;
    logic                                        ready;
    logic                                        is_real;
    logic signed [DW+m2e_pkg::LAMBDA_EXTRA-1:0]  lambda_lo;
    logic signed [DW+m2e_pkg::LAMBDA_EXTRA-1:0]  lambda_hi;
    logic signed [DW-1:0]                        vec_lo_x;
    logic signed [DW+m2e_pkg::VEC_EXTRA-1:0]     vec_lo_y;
    logic signed [DW-1:0]                        vec_hi_x;
    logic signed [DW+m2e_pkg::VEC_EXTRA-1:0]     vec_hi_y;

    modport source (output valid, is_real, lambda_lo, lambda_hi, vec_lo_x, vec_lo_y,
                     vec_hi_x, vec_hi_y, input ready);
    modport sink   (input valid, is_real, lambda_lo, lambda_hi, vec_lo_x, vec_lo_y,
                     vec_hi_x, vec_hi_y, output ready);
endinterface

@@ hdl/m2e_prep.sv @@
// Three-stage front end: trace, products, determinant, square of trace, discriminant.
module m2e_prep #(
    parameter int DW = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [DW-1:0]                   i_m00,
    input  logic signed [DW-1:0]                   i_m01,
    input  logic signed [DW-1:0]                   i_m10,
    input  logic signed [DW-1:0]                   i_m11,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [DW:0]                     o_tr,
    output logic signed [DW-1:0]                   o_a00,
    output logic signed [DW-1:0]                   o_a01,
    output logic                                   o_neg,
    output logic [2*(DW+m2e_pkg::ROOT_EXTRA)-1:0]  o_rad
);

    localparam int DSW = 2 * (DW + m2e_pkg::ROOT_EXTRA);

    logic                   r_v0, r_v1, r_v2;
    logic                   w_rdy1, w_rdy2;

    logic signed [DW:0]     r0_tr, r1_tr, r2_tr;
    logic signed [DW-1:0]   r0_a00, r1_a00, r2_a00;
    logic signed [DW-1:0]   r0_a01, r1_a01, r2_a01;
    logic signed [2*DW-1:0] r0_p0, r0_p1;
    logic signed [2*DW:0]   r1_det;
    logic signed [2*DW+1:0] r1_trsq;
    logic                   r2_neg;
    logic [DSW-1:0]         r2_rad;

    logic signed [DW:0]     n0_tr;
    logic signed [2*DW-1:0] n0_p0, n0_p1;
    logic signed [2*DW:0]   n1_det;
    logic signed [2*DW+1:0] n1_trsq;
    logic signed [DSW-1:0]  n2_disc;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = !r_v0 || w_rdy1;

    assign n0_tr   = (DW+1)'(i_m00) + (DW+1)'(i_m11);
    assign n0_p0   = i_m00 * i_m11;
    assign n0_p1   = i_m01 * i_m10;
    assign n1_det  = (2*DW+1)'(r0_p0) - (2*DW+1)'(r0_p1);
    assign n1_trsq = r0_tr * r0_tr;
    assign n2_disc = DSW'(r1_trsq) - (DSW'(r1_det) <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) r_v0 <= i_valid;
            if (w_rdy1)  r_v1 <= r_v0;
            if (w_rdy2)  r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r0_tr  <= n0_tr;
            r0_a00 <= i_m00;
            r0_a01 <= i_m01;
            r0_p0  <= n0_p0;
            r0_p1  <= n0_p1;
        end
        if (r_v0 && w_rdy1) begin
            r1_tr   <= r0_tr;
            r1_a00  <= r0_a00;
            r1_a01  <= r0_a01;
            r1_det  <= n1_det;
            r1_trsq <= n1_trsq;
        end
        if (r_v1 && w_rdy2) begin
            r2_tr  <= r1_tr;
            r2_a00 <= r1_a00;
            r2_a01 <= r1_a01;
            r2_neg <= n2_disc[DSW-1];
            r2_rad <= n2_disc;
        end
    end

    assign o_valid = r_v2;
    assign o_tr    = r2_tr;
    assign o_a00   = r2_a00;
    assign o_a01   = r2_a01;
    assign o_neg   = r2_neg;
    assign o_rad   = r2_rad;

endmodule

@@ hdl/m2e_sqrt_cell.sv @@
// One square root cell: settles one root bit from two radicand bits and passes on.
module m2e_sqrt_cell #(
    parameter int RW = 18,
    parameter int PW = 50
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [2*RW-1:0] i_rad,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root,
    output logic [2*RW-1:0] o_rad,
    output logic [PW-1:0]   o_pay
);

    logic            r_valid;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [2*RW-1:0] r_rad;
    logic [PW-1:0]   r_pay;

    logic [RW+3:0]   w_cur;
    logic [RW+3:0]   w_trial;
    logic [RW+3:0]   w_diff;
    logic            w_fit;
    logic [RW+1:0]   n_rem;
    logic [RW-1:0]   n_root;

    // bring down the next radicand pair and try root bit one
    assign w_cur   = {i_rem, i_rad[2*RW-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_fit   = (w_cur >= w_trial);
    assign n_rem   = w_fit ? w_diff[RW+1:0] : w_cur[RW+1:0];
    assign n_root  = {i_root[RW-2:0], w_fit};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[2*RW-3:0], 2'b00};
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_pay   = r_pay;

`ifndef SYNTHESIS
    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem <= {1'b0, r_root, 1'b0}))
        else $error("sqrt cell remainder out of bound");

    // a stalled cell keeps its transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_root) && $stable(r_rem)))
        else $error("sqrt cell lost a stalled transaction");
`endif

endmodule

@@ hdl/matrix2x2_real_eigen.sv @@
// Throughput: one matrix per cycle while the output is not stalled, through three front
// stages, one square root cell per root bit, and one output register, each advancing
// whenever its successor is empty or moving.
// A stalled output lets earlier stages keep filling until the chain is full.
// Reset (synchronous, active low) clears every stage valid bit; payload is not reset.
// Top level: real eigenvalues and eigenvectors of a 2x2 signed fixed-point matrix.
module matrix2x2_real_eigen #(
    parameter int DATA_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    m2e_in_if.sink       i_in,
    m2e_out_if.source    o_out
);

    localparam int DW  = DATA_WIDTH;
    localparam int RW  = DW + m2e_pkg::ROOT_EXTRA;
    localparam int PW  = 3 * DW + 2;
    localparam int LW  = DW + m2e_pkg::LAMBDA_EXTRA;
    localparam int VW  = DW + m2e_pkg::VEC_EXTRA;

    logic            w_valid [0:RW];
    logic            w_ready [0:RW];
    logic [RW+1:0]   w_rem   [0:RW];
    logic [RW-1:0]   w_root  [0:RW];
    logic [2*RW-1:0] w_rad   [0:RW];
    logic [PW-1:0]   w_pay   [0:RW];

    logic signed [DW:0]   w_p_tr;
    logic signed [DW-1:0] w_p_a00;
    logic signed [DW-1:0] w_p_a01;
    logic                 w_p_neg;

    m2e_prep #(
        .DW (DW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_m00   (i_in.m00),
        .i_m01   (i_in.m01),
        .i_m10   (i_in.m10),
        .i_m11   (i_in.m11),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_tr    (w_p_tr),
        .o_a00   (w_p_a00),
        .o_a01   (w_p_a01),
        .o_neg   (w_p_neg),
        .o_rad   (w_rad[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_pay[0]  = {w_p_tr, w_p_a00, w_p_a01, w_p_neg};

    for (genvar k = 0; k < RW; k++) begin : g_cell
        m2e_sqrt_cell #(
            .RW (RW),
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_rad   (w_rad[k]),
            .i_pay   (w_pay[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_pay   (w_pay[k+1])
        );
    end

    // unpack the payload at the chain end
    logic signed [DW:0]   w_tr;
    logic signed [DW-1:0] w_a00;
    logic signed [DW-1:0] w_a01;
    logic                 w_neg;
    logic signed [LW-1:0] w_root_x;
    logic signed [LW-1:0] w_sum_lo, w_sum_hi;
    logic signed [LW-1:0] w_lam_lo, w_lam_hi;

    assign w_tr  = w_pay[RW][PW-1 -: DW+1];
    assign w_a00 = w_pay[RW][2*DW:DW+1];
    assign w_a01 = w_pay[RW][DW:1];
    assign w_neg = w_pay[RW][0];

    // a zero determinant gives root = |trace|, which already yields min/max(trace, 0)
    assign w_root_x = signed'({1'b0, w_root[RW]});
    assign w_sum_lo = LW'(w_tr) - w_root_x;
    assign w_sum_hi = LW'(w_tr) + w_root_x;
    assign w_lam_lo = w_sum_lo >>> 1;
    assign w_lam_hi = w_sum_hi >>> 1;

    logic                 r_out_valid;
    logic                 r_is_real;
    logic signed [LW-1:0] r_lam_lo, r_lam_hi;
    logic signed [DW-1:0] r_vlo_x, r_vhi_x;
    logic signed [VW-1:0] r_vlo_y, r_vhi_y;

    assign w_ready[RW] = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[RW]) begin
            r_out_valid <= w_valid[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_valid[RW] && w_ready[RW]) begin
            if (w_neg) begin
                // complex pair: drop everything to zero
                r_is_real <= 1'b0;
                r_lam_lo  <= '0;
                r_lam_hi  <= '0;
                r_vlo_x   <= '0;
                r_vhi_x   <= '0;
                r_vlo_y   <= '0;
                r_vhi_y   <= '0;
            end else begin
                r_is_real <= 1'b1;
                r_lam_lo  <= w_lam_lo;
                r_lam_hi  <= w_lam_hi;
                r_vlo_x   <= w_a01;
                r_vhi_x   <= w_a01;
                r_vlo_y   <= VW'(w_lam_lo) - VW'(w_a00);
                r_vhi_y   <= VW'(w_lam_hi) - VW'(w_a00);
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.is_real   = r_is_real;
    assign o_out.lambda_lo = r_lam_lo;
    assign o_out.lambda_hi = r_lam_hi;
    assign o_out.vec_lo_x  = r_vlo_x;
    assign o_out.vec_lo_y  = r_vlo_y;
    assign o_out.vec_hi_x  = r_vhi_x;
    assign o_out.vec_hi_y  = r_vhi_y;

`ifndef SYNTHESIS
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_real) |-> (r_lam_lo <= r_lam_hi))
        else $error("eigenvalues out of order");

    a_vec_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_vhi_y - r_vlo_y) == (VW'(r_lam_hi) - VW'(r_lam_lo))))
        else $error("eigenvector gap does not match eigenvalue gap");
`endif

endmodule

@@ test/matrix2x2_real_eigen_test.sv @@
// Testbench for matrix2x2_real_eigen: random and corner-case matrices, checked against a local predictor.
`timescale 1ns / 100ps

localparam int MAT_W = 16;
localparam int LAM_W = MAT_W + m2e_pkg::LAMBDA_EXTRA;
localparam int VEC_W = MAT_W + m2e_pkg::VEC_EXTRA;

typedef struct packed {
    logic                    is_real;
    logic signed [LAM_W-1:0] lambda_lo;
    logic signed [LAM_W-1:0] lambda_hi;
    logic signed [MAT_W-1:0] vec_lo_x;
    logic signed [VEC_W-1:0] vec_lo_y;
    logic signed [MAT_W-1:0] vec_hi_x;
    logic signed [VEC_W-1:0] vec_hi_y;
} eigen_t;

typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_TRICKLE, RX_PERIODIC} rx_mode_t;

class eigen_checker;
    eigen_t expected_eigen[$];
    int     matrices;
    int     results;
    int     mismatches;
    int     real_cnt;
    int     complex_cnt;
    int     singular_cnt;

    function new();
        matrices     = 0;
        results      = 0;
        mismatches   = 0;
        real_cnt     = 0;
        complex_cnt  = 0;
        singular_cnt = 0;
    endfunction

    // floored square root; the discriminant stays below 2^36
    function longint floor_sqrt(longint n);
        longint root;
        longint cand;
        root = 0;
        for (int b = 18; b >= 0; b--) begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= n)
                root = cand;
        end
        return root;
    endfunction

    function eigen_t eigen_pair(logic signed [MAT_W-1:0] a00, logic signed [MAT_W-1:0] a01,
                                logic signed [MAT_W-1:0] a10, logic signed [MAT_W-1:0] a11);
        longint tr;
        longint det;
        longint disc;
        longint root;
        longint lo;
        longint hi;
        longint dy;
        eigen_t res;
        res = '0;
        tr  = longint'(a00) + longint'(a11);
        det = longint'(a00) * longint'(a11) - longint'(a01) * longint'(a10);
        if (det == 0) begin
            singular_cnt++;
            lo = (tr < 0) ? tr : 0;
            hi = (tr < 0) ? 0 : tr;
        end else begin
            disc = tr * tr - 4 * det;
            if (disc < 0)
                return res;
            root = floor_sqrt(disc);
            lo   = (tr - root) >>> 1;
            hi   = (tr + root) >>> 1;
        end
        res.is_real   = 1'b1;
        res.lambda_lo = lo[LAM_W-1:0];
        res.lambda_hi = hi[LAM_W-1:0];
        res.vec_lo_x  = a01;
        res.vec_hi_x  = a01;
        dy            = lo - longint'(a00);
        res.vec_lo_y  = dy[VEC_W-1:0];
        dy            = hi - longint'(a00);
        res.vec_hi_y  = dy[VEC_W-1:0];
        return res;
    endfunction

    function void note_matrix(logic signed [MAT_W-1:0] a00, logic signed [MAT_W-1:0] a01,
                              logic signed [MAT_W-1:0] a10, logic signed [MAT_W-1:0] a11);
        eigen_t want;
        want = eigen_pair(a00, a01, a10, a11);
        matrices++;
        if (want.is_real)
            real_cnt++;
        else
            complex_cnt++;
        expected_eigen.push_back(want);
    endfunction

    function void check_eigen(eigen_t got);
        eigen_t want;
        results++;
        if (expected_eigen.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d arrived with no matrix outstanding", results);
            return;
        end
        want = expected_eigen.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: result %0d mismatch", results);
                $display("  expected real=%0b lo=%0d hi=%0d vlo=(%0d,%0d) vhi=(%0d,%0d)",
                         want.is_real, want.lambda_lo, want.lambda_hi, want.vec_lo_x,
                         want.vec_lo_y, want.vec_hi_x, want.vec_hi_y);
                $display("  actual   real=%0b lo=%0d hi=%0d vlo=(%0d,%0d) vhi=(%0d,%0d)",
                         got.is_real, got.lambda_lo, got.lambda_hi, got.vec_lo_x,
                         got.vec_lo_y, got.vec_hi_x, got.vec_hi_y);
            end
        end
    endfunction
endclass

module matrix2x2_real_eigen_test;

    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [63:0] CORNER [18] = '{
        64'h0000_0000_0000_0000,  // all zero
        64'h0100_0000_0000_0100,  // identity
        64'h7FFF_7FFF_7FFF_7FFF,  // all max, singular
        64'h8000_8000_8000_8000,  // all min, singular with negative trace
        64'h7FFF_8000_8000_8000,  // large negative determinant
        64'h0000_7FFF_8000_0000,  // widest complex pair
        64'hFF00_0000_0000_0000,  // singular, negative trace
        64'h0200_0100_0200_0100,  // singular, positive trace
        64'h0000_FF00_0100_0000,  // pure rotation, complex
        64'h0100_0100_0000_0100,  // repeated root, discriminant zero
        64'hFFFF_0001_0001_0000,  // odd negative sum, halving rounds down
        64'h8000_0000_0000_8000,  // repeated root at the negative extreme
        64'h5555_AAAA_AAAA_5555,
        64'hAAAA_5555_5555_AAAA,
        64'h7FFF_0000_0000_8000,  // widest spread of eigenvalues
        64'h8000_7FFF_7FFF_8000,
        64'hFFFF_0003_0002_FFFE,  // discriminant of 25, an exact square
        64'h8000_8000_7FFF_7FFF   // singular, trace of minus one LSB
    };

    logic clk;
    logic rst_n;

    m2e_in_if  #(.DW(MAT_W)) in_bus ();
    m2e_out_if #(.DW(MAT_W)) out_bus ();

    matrix2x2_real_eigen #(
        .DATA_WIDTH(MAT_W)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    eigen_checker sb = new();

    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_phase;
    int       idle_cycles;
    int       burst_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // record input transactions and check result transactions
    always @(posedge clk) begin
        eigen_t got;
        if (rst_n && in_bus.valid && in_bus.ready)
            sb.note_matrix(in_bus.m00, in_bus.m01, in_bus.m10, in_bus.m11);
        if (rst_n && out_bus.valid && out_bus.ready) begin
            got.is_real   = out_bus.is_real;
            got.lambda_lo = out_bus.lambda_lo;
            got.lambda_hi = out_bus.lambda_hi;
            got.vec_lo_x  = out_bus.vec_lo_x;
            got.vec_lo_y  = out_bus.vec_lo_y;
            got.vec_hi_x  = out_bus.vec_hi_x;
            got.vec_hi_y  = out_bus.vec_hi_y;
            sb.check_eigen(got);
        end
    end

    // receiver backpressure: switch to a randomly chosen stall pattern after each run of random length
    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            rx_mode       <= RX_STREAM;
            rx_left       <= 0;
            rx_phase      <= 0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 300);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_STREAM:   out_bus.ready <= 1'b1;
                RX_COIN:     out_bus.ready <= 1'($urandom_range(0, 1));
                RX_TRICKLE:  out_bus.ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: out_bus.ready <= (rx_phase % 7) < 4;
                default:     out_bus.ready <= 1'b1;
            endcase
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.expected_eigen.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // hold one matrix on the input until accepted; insert gaps between bursts
    task automatic send_matrix(input logic [MAT_W-1:0] a00, input logic [MAT_W-1:0] a01,
                               input logic [MAT_W-1:0] a10, input logic [MAT_W-1:0] a11);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        in_bus.valid <= 1'b1;
        in_bus.m00   <= a00;
        in_bus.m01   <= a01;
        in_bus.m10   <= a10;
        in_bus.m11   <= a11;
        do @(posedge clk); while (!in_bus.ready);
        burst_left--;
    endtask

    initial begin
        logic [MAT_W-1:0] a00;
        logic [MAT_W-1:0] a01;
        logic [MAT_W-1:0] a10;
        logic [MAT_W-1:0] a11;
        int               p;
        int               q;
        int               r;
        int               s;
        int               pick;

        rst_n        <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.m00   <= '0;
        in_bus.m01   <= '0;
        in_bus.m10   <= '0;
        in_bus.m11   <= '0;
        burst_left   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER[i])
            send_matrix(CORNER[i][63:48], CORNER[i][47:32], CORNER[i][31:16], CORNER[i][15:0]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                a00 = 16'($urandom);
                a01 = 16'($urandom);
                a10 = 16'($urandom);
                a11 = 16'($urandom);
            end else if (pick < 55) begin
                a00 = 16'(int'($urandom_range(0, 2047)) - 1024);
                a01 = 16'(int'($urandom_range(0, 2047)) - 1024);
                a10 = 16'(int'($urandom_range(0, 2047)) - 1024);
                a11 = 16'(int'($urandom_range(0, 2047)) - 1024);
            end else if (pick < 72) begin
                // rank-one matrix: determinant is exactly zero
                p   = int'($urandom_range(0, 362)) - 181;
                q   = int'($urandom_range(0, 362)) - 181;
                r   = int'($urandom_range(0, 362)) - 181;
                s   = int'($urandom_range(0, 362)) - 181;
                a00 = 16'(p * r);
                a01 = 16'(p * s);
                a10 = 16'(q * r);
                a11 = 16'(q * s);
            end else if (pick < 88) begin
                // off-diagonal terms of opposite sign lean toward complex pairs
                a00 = 16'(int'($urandom_range(0, 4095)) - 2048);
                a11 = 16'(int'($urandom_range(0, 4095)) - 2048);
                a01 = 16'($urandom_range(1, 32767));
                a10 = 16'(-int'($urandom_range(1, 32768)));
                if ($urandom_range(0, 1)) begin
                    a01 = -a01;
                    a10 = -a10;
                end
            end else begin
                // symmetric: always real
                a00 = 16'($urandom);
                a01 = 16'($urandom);
                a10 = a01;
                a11 = 16'($urandom);
            end
            send_matrix(a00, a01, a10, a11);
        end
        in_bus.valid <= 1'b0;

        while (sb.expected_eigen.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d matrices: %0d real (%0d singular), %0d complex.",
                 sb.matrices, sb.real_cnt, sb.singular_cnt, sb.complex_cnt);
        $display("Checked %0d results under random input gaps and output stalls, %0d mismatches.",
                 sb.results, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_eigen.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
